// ----- rtl/rbaf_pkg.sv -----
`default_nettype none
package rbaf_pkg;

	localparam int MAX_WINDOW  = 16;
	localparam int RANGE_LIMIT = 200;
	localparam int AVG_MAX     = RANGE_LIMIT * 256;

	localparam int SUM_W  = 16;
	localparam int CNT_W  = 8;
	localparam int VAL_W  = 16;
	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int TOT_W  = $clog2(MAX_WINDOW * AVG_MAX + 1);
	localparam int DVD_W  = (TOT_W > SUM_W + 8) ? TOT_W : SUM_W + 8;
	localparam int DVS_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;
	localparam int STEP_W = $clog2(DVD_W + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BURST_SIZE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

	typedef struct packed {
		logic [7:0]  burst_size;
		logic [4:0]  window_length;
		logic [15:0] change_threshold;
	} cfg_t;

	typedef struct packed {
		logic             no_valid;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_AVG,
		B_RD,
		B_WAVG,
		B_DEAD
	} b_state_t;

endpackage
`default_nettype wire

// ----- rtl/rbaf_in_if.sv -----
`default_nettype none
interface rbaf_in_if;
	logic       valid;
	logic       ready;
	logic       reading_arrived;
	logic [3:0] fault_code;
	logic [7:0] range_mm;

	modport source (output valid, output reading_arrived, output fault_code,
		output range_mm, input ready);
	modport sink (input valid, input reading_arrived, input fault_code,
		input range_mm, output ready);
endinterface
`default_nettype wire

// ----- rtl/rbaf_out_if.sv -----
`default_nettype none
interface rbaf_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance;
	logic        publish;
	logic        no_valid;

	modport source (output valid, output distance, output publish, output no_valid,
		input ready);
	modport sink (input valid, input distance, input publish, input no_valid,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/rbaf_cfg_if.sv -----
`default_nettype none
interface rbaf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rbaf_pkg::CFG_IDX_W-1:0]    index;
	logic [rbaf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/range_burst_average_filter.sv -----
// Burst-averaging range filter. One ranging attempt word is taken per cycle
// on sample while the two-entry burst queue has room; only the word that
// closes a burst enters the queue. The back end works one burst at a time
// through a shared one-bit-per-cycle divider (24 steps): an unfiltered
// burst is popped from the queue, its sum divided by its count and the
// average loaded into the result register; a filtered one (window_length
// above 1) also reads the window and divides a second time. An empty
// burst skips both divides. The front end keeps taking words while the
// back end works, until the queue is full. Results wait in an output
// register so the back end can begin the next burst. Configuration writes
// are always ready; writing window_length restarts the moving average.
`default_nettype none
module range_burst_average_filter (
	input  wire logic clk,
	input  wire logic arst_n,
	rbaf_in_if.sink   sample,
	rbaf_out_if.source result,
	rbaf_cfg_if.sink  cfg
);

	rbaf_pkg::cfg_t cfg_regs_q;
	logic           cfg_wr;
	logic           win_clear;
	logic           push;
	rbaf_pkg::job_t push_data;
	logic           full;
	logic           pop;
	rbaf_pkg::job_t pop_data;
	logic           not_empty;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign win_clear = cfg_wr && (cfg.index == rbaf_pkg::REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.burst_size       <= 8'd1;
			cfg_regs_q.window_length    <= 5'd1;
			cfg_regs_q.change_threshold <= 16'd0;
		end else if (cfg_wr) begin
			case (cfg.index)
				rbaf_pkg::REG_BURST_SIZE: begin
					cfg_regs_q.burst_size <= cfg.data[7:0];
				end
				rbaf_pkg::REG_WINDOW_LENGTH: begin
					cfg_regs_q.window_length <= cfg.data[4:0];
				end
				rbaf_pkg::REG_CHANGE_THRESHOLD: begin
					cfg_regs_q.change_threshold <= cfg.data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	rbaf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs_q),
		.sample    (sample),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	rbaf_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	rbaf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs_q),
		.win_clear (win_clear),
		.job_valid (not_empty),
		.job       (pop_data),
		.job_pop   (pop),
		.result    (result)
	);

endmodule
`default_nettype wire

// ----- rtl/rbaf_fifo.sv -----
`default_nettype none
module rbaf_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rbaf_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output rbaf_pkg::job_t     pop_data,
	output logic               not_empty
);

	rbaf_pkg::job_t                   mem_q [rbaf_pkg::QUEUE_DEPTH];
	logic [rbaf_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [rbaf_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [rbaf_pkg::QCNT_W-1:0]      count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full      = (count_q == rbaf_pkg::QCNT_W'(rbaf_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rbaf_pkg::QPTR_W'(rbaf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rbaf_pkg::QPTR_W'(rbaf_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rbaf_front.sv -----
`default_nettype none
module rbaf_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rbaf_pkg::cfg_t cfg,
	rbaf_in_if.sink         sample,
	output logic            push,
	output rbaf_pkg::job_t  push_data,
	input  wire logic       full
);

	logic [7:0]                 attempt_q;
	logic [rbaf_pkg::SUM_W-1:0] sum_q;
	logic [rbaf_pkg::CNT_W-1:0] vcount_q;
	logic                       accept;
	logic                       good;
	logic [7:0]                 size;
	logic                       burst_end;
	logic [rbaf_pkg::SUM_W-1:0] sum_next;
	logic [rbaf_pkg::CNT_W-1:0] vcount_next;

	assign sample.ready = !full;
	assign accept       = sample.valid && sample.ready;

	always_comb begin
		good = sample.reading_arrived && (sample.fault_code == 4'd0) &&
			(sample.range_mm <= 8'(rbaf_pkg::RANGE_LIMIT));
		size        = (cfg.burst_size == 8'd0) ? 8'd1 : cfg.burst_size;
		burst_end   = ({1'b0, attempt_q} + 9'd1) >= {1'b0, size};
		sum_next    = good ? sum_q + rbaf_pkg::SUM_W'(sample.range_mm) : sum_q;
		vcount_next = good ? vcount_q + 1'b1 : vcount_q;
		push_data.no_valid = (vcount_next == '0);
		push_data.sum      = sum_next;
		push_data.count    = vcount_next;
		push = accept && burst_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_q <= '0;
			sum_q     <= '0;
			vcount_q  <= '0;
		end else if (accept) begin
			if (burst_end) begin
				attempt_q <= '0;
				sum_q     <= '0;
				vcount_q  <= '0;
			end else begin
				attempt_q <= attempt_q + 1'b1;
				sum_q     <= sum_next;
				vcount_q  <= vcount_next;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rbaf_div.sv -----
`default_nettype none
module rbaf_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rbaf_pkg::DVD_W-1:0] dividend,
	input  wire logic [rbaf_pkg::DVS_W-1:0] divisor,
	output logic                            busy,
	output logic                            done,
	output logic [rbaf_pkg::DVD_W-1:0]      quotient
);

	logic [rbaf_pkg::DVD_W-1:0]  quo_q;
	logic [rbaf_pkg::DVS_W:0]    rem_q;
	logic [rbaf_pkg::DVS_W-1:0]  dvs_q;
	logic [rbaf_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rbaf_pkg::DVS_W:0]    rem_sh;
	logic                        ge;

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q[rbaf_pkg::DVS_W-1:0], quo_q[rbaf_pkg::DVD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= rbaf_pkg::STEP_W'(rbaf_pkg::DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == rbaf_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[rbaf_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rbaf_ram.sv -----
`default_nettype none
module rbaf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/rbaf_back.sv -----
`default_nettype none
module rbaf_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rbaf_pkg::cfg_t cfg,
	input  wire logic       win_clear,
	input  wire logic       job_valid,
	input  wire rbaf_pkg::job_t job,
	output logic            job_pop,
	rbaf_out_if.source      result
);

	rbaf_pkg::b_state_t         state_q;
	rbaf_pkg::b_state_t         state_d;
	logic                       nv_q;
	logic [rbaf_pkg::VAL_W-1:0] avg_q;
	logic [rbaf_pkg::VAL_W-1:0] val_q;
	logic [rbaf_pkg::TOT_W-1:0] total_q;
	logic [rbaf_pkg::WIN_W-1:0] fill_q;
	logic [rbaf_pkg::PTR_W-1:0] ptr_q;
	logic [rbaf_pkg::VAL_W-1:0] last_q;
	logic                       have_last_q;
	logic                       out_valid_q;
	logic [rbaf_pkg::VAL_W-1:0] out_dist_q;
	logic                       out_pub_q;
	logic                       out_nv_q;

	logic [rbaf_pkg::WIN_W-1:0] eff_w;
	logic                       filtered;
	logic [rbaf_pkg::VAL_W-1:0] old_val;
	logic                       ram_we;
	logic [rbaf_pkg::TOT_W-1:0] total_new;
	logic [rbaf_pkg::WIN_W-1:0] fill_new;
	logic [rbaf_pkg::WIN_W-1:0] ptr_inc;
	logic [rbaf_pkg::PTR_W-1:0] ptr_new;
	logic                       div_start;
	logic [rbaf_pkg::DVD_W-1:0] div_dividend;
	logic [rbaf_pkg::DVS_W-1:0] div_divisor;
	logic                       div_busy;
	logic                       div_done;
	logic [rbaf_pkg::DVD_W-1:0] div_quot;
	logic [rbaf_pkg::VAL_W-1:0] diff;
	logic                       pub;
	logic                       out_load;

	rbaf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	rbaf_ram #(
		.WIDTH (rbaf_pkg::VAL_W),
		.DEPTH (rbaf_pkg::MAX_WINDOW)
	) u_win (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (avg_q),
		.raddr (ptr_q),
		.rdata (old_val)
	);

	always_comb begin
		if (cfg.window_length == 5'd0) begin
			eff_w = rbaf_pkg::WIN_W'(1);
		end else if (32'(cfg.window_length) > rbaf_pkg::MAX_WINDOW) begin
			eff_w = rbaf_pkg::WIN_W'(rbaf_pkg::MAX_WINDOW);
		end else begin
			eff_w = rbaf_pkg::WIN_W'(cfg.window_length);
		end
		filtered = (eff_w > rbaf_pkg::WIN_W'(1));

		if (fill_q < eff_w) begin
			fill_new  = fill_q + 1'b1;
			total_new = total_q + rbaf_pkg::TOT_W'(avg_q);
		end else begin
			fill_new  = fill_q;
			total_new = total_q - rbaf_pkg::TOT_W'(old_val) + rbaf_pkg::TOT_W'(avg_q);
		end
		ptr_inc = rbaf_pkg::WIN_W'(ptr_q) + rbaf_pkg::WIN_W'(1);
		ptr_new = (ptr_inc == eff_w) ? '0 : rbaf_pkg::PTR_W'(ptr_inc);

		diff = (val_q > last_q) ? val_q - last_q : last_q - val_q;
		pub  = !((cfg.change_threshold != '0) && have_last_q &&
			(diff < cfg.change_threshold));
	end

	always_comb begin
		state_d      = state_q;
		job_pop      = 1'b0;
		div_start    = 1'b0;
		div_dividend = rbaf_pkg::DVD_W'({job.sum, 8'h00});
		div_divisor  = rbaf_pkg::DVS_W'(job.count);
		ram_we       = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			rbaf_pkg::B_IDLE: begin
				if (job_valid) begin
					job_pop   = 1'b1;
					div_start = !job.no_valid;
					state_d   = job.no_valid ? rbaf_pkg::B_DEAD : rbaf_pkg::B_AVG;
				end
			end
			rbaf_pkg::B_AVG: begin
				if (div_done) begin
					state_d = filtered ? rbaf_pkg::B_RD : rbaf_pkg::B_DEAD;
				end
			end
			rbaf_pkg::B_RD: begin
				ram_we       = 1'b1;
				div_start    = 1'b1;
				div_dividend = rbaf_pkg::DVD_W'(total_new);
				div_divisor  = rbaf_pkg::DVS_W'(fill_new);
				state_d      = rbaf_pkg::B_WAVG;
			end
			rbaf_pkg::B_WAVG: begin
				if (div_done) begin
					state_d = rbaf_pkg::B_DEAD;
				end
			end
			rbaf_pkg::B_DEAD: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = rbaf_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = rbaf_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbaf_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			last_q      <= '0;
			have_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (win_clear) begin
				total_q <= '0;
				fill_q  <= '0;
				ptr_q   <= '0;
			end else if (state_q == rbaf_pkg::B_RD) begin
				total_q <= total_new;
				fill_q  <= fill_new;
				ptr_q   <= ptr_new;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (!nv_q && pub) begin
					last_q      <= val_q;
					have_last_q <= 1'b1;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			nv_q  <= job.no_valid;
			val_q <= '0;
		end
		if (state_q == rbaf_pkg::B_AVG && div_done) begin
			avg_q <= div_quot[rbaf_pkg::VAL_W-1:0];
			val_q <= div_quot[rbaf_pkg::VAL_W-1:0];
		end
		if (state_q == rbaf_pkg::B_WAVG && div_done) begin
			val_q <= div_quot[rbaf_pkg::VAL_W-1:0];
		end
		if (out_load) begin
			out_dist_q <= val_q;
			out_pub_q  <= !nv_q && pub;
			out_nv_q   <= nv_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.distance = out_dist_q;
	assign result.publish  = out_pub_q;
	assign result.no_valid = out_nv_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= rbaf_pkg::MAX_WINDOW)
		else $error("window fill above depth");

	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rbaf_pkg::WIN_W'(ptr_q) <= fill_q)
		else $error("window pointer ahead of fill");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_nv_q) |-> (!out_pub_q && out_dist_q == '0))
		else $error("empty burst word carries a value");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule
`default_nettype wire
